// ----- hdl/elh_pkg.sv -----
// shared types, constants and the triplet order table of the edge hessian block
`timescale 1ns / 1ps

package elh_pkg;

    localparam int MAX_VERTICES = 65536;
    localparam int VTX_W        = 17;
    localparam int COORD_W      = 32;
    localparam int LEN_W        = 31;
    localparam int IDX_W        = 18;
    localparam int VAL_W        = 64;
    localparam int D_W          = COORD_W + 1;
    localparam int PROD_W       = 2 * D_W;
    localparam int ACC_W        = 72;
    localparam int TRIPLETS     = 36;
    localparam int K_W          = 6;
    localparam int SLOTS        = 6;
    localparam int KINDS        = 6;
    localparam int AXES         = 3;
    localparam int MUL_STEPS    = 7;
    localparam int STEP_W       = 4;
    localparam int QUEUE_DEPTH  = 2;

    // front sequencer steps
    localparam logic [STEP_W-1:0] STEP_LL   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_XX   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_YY   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_ZZ   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_XY   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_XZ   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_YZ   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_DIAG = 4'd7;
    localparam logic [STEP_W-1:0] STEP_PUSH = 4'd8;

    // index slots
    localparam logic [2:0] SLOT_XI = 3'd0;
    localparam logic [2:0] SLOT_YI = 3'd1;
    localparam logic [2:0] SLOT_ZI = 3'd2;
    localparam logic [2:0] SLOT_XJ = 3'd3;
    localparam logic [2:0] SLOT_YJ = 3'd4;
    localparam logic [2:0] SLOT_ZJ = 3'd5;

    // value kinds
    localparam logic [2:0] KIND_XX = 3'd0;
    localparam logic [2:0] KIND_YY = 3'd1;
    localparam logic [2:0] KIND_ZZ = 3'd2;
    localparam logic [2:0] KIND_XY = 3'd3;
    localparam logic [2:0] KIND_XZ = 3'd4;
    localparam logic [2:0] KIND_YZ = 3'd5;

    localparam logic POS = 1'b0;
    localparam logic NEG = 1'b1;

    typedef struct packed {
        logic [VTX_W-1:0]          first_vertex;
        logic [VTX_W-1:0]          second_vertex;
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
        logic [LEN_W-1:0]          target_length;
        logic                      mesh_final_edge;
    } t_edge_in;

    typedef struct packed {
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [VAL_W-1:0] entry_value;
        logic                    last_of_edge;
        logic                    mesh_done;
    } t_trip_out;

    typedef struct packed {
        logic [KINDS-1:0][ACC_W-1:0] vals;
        logic [SLOTS-1:0][IDX_W-1:0] slot;
        logic                        fin;
    } t_qentry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic [2:0] row_slot;
        logic [2:0] col_slot;
        logic [2:0] kind;
        logic       neg;
    } t_tab;

    function automatic t_tab tab_lookup(input logic [K_W-1:0] k);
        t_tab e;
        case (k)
            6'd0:    e = '{SLOT_XI, SLOT_XI, KIND_XX, POS};
            6'd1:    e = '{SLOT_XJ, SLOT_XJ, KIND_XX, POS};
            6'd2:    e = '{SLOT_YI, SLOT_YI, KIND_YY, POS};
            6'd3:    e = '{SLOT_YJ, SLOT_YJ, KIND_YY, POS};
            6'd4:    e = '{SLOT_ZI, SLOT_ZI, KIND_ZZ, POS};
            6'd5:    e = '{SLOT_ZJ, SLOT_ZJ, KIND_ZZ, POS};
            6'd6:    e = '{SLOT_XI, SLOT_YI, KIND_XY, POS};
            6'd7:    e = '{SLOT_YI, SLOT_XI, KIND_XY, POS};
            6'd8:    e = '{SLOT_ZI, SLOT_XI, KIND_XZ, POS};
            6'd9:    e = '{SLOT_XI, SLOT_ZI, KIND_XZ, POS};
            6'd10:   e = '{SLOT_YI, SLOT_ZI, KIND_YZ, POS};
            6'd11:   e = '{SLOT_ZI, SLOT_YI, KIND_YZ, POS};
            6'd12:   e = '{SLOT_XI, SLOT_XJ, KIND_XX, NEG};
            6'd13:   e = '{SLOT_XJ, SLOT_XI, KIND_XX, NEG};
            6'd14:   e = '{SLOT_YI, SLOT_YJ, KIND_YY, NEG};
            6'd15:   e = '{SLOT_YJ, SLOT_YI, KIND_YY, NEG};
            6'd16:   e = '{SLOT_ZI, SLOT_ZJ, KIND_ZZ, NEG};
            6'd17:   e = '{SLOT_ZJ, SLOT_ZI, KIND_ZZ, NEG};
            6'd18:   e = '{SLOT_XI, SLOT_YJ, KIND_XY, NEG};
            6'd19:   e = '{SLOT_YJ, SLOT_XI, KIND_XY, NEG};
            6'd20:   e = '{SLOT_ZJ, SLOT_XI, KIND_XZ, NEG};
            6'd21:   e = '{SLOT_XI, SLOT_ZJ, KIND_XZ, NEG};
            6'd22:   e = '{SLOT_YI, SLOT_XJ, KIND_XY, NEG};
            6'd23:   e = '{SLOT_XJ, SLOT_YI, KIND_XY, NEG};
            6'd24:   e = '{SLOT_YI, SLOT_ZJ, KIND_YZ, NEG};
            6'd25:   e = '{SLOT_ZJ, SLOT_YI, KIND_YZ, NEG};
            6'd26:   e = '{SLOT_XJ, SLOT_ZI, KIND_XZ, NEG};
            6'd27:   e = '{SLOT_ZI, SLOT_XJ, KIND_XZ, NEG};
            6'd28:   e = '{SLOT_YJ, SLOT_ZI, KIND_YZ, NEG};
            6'd29:   e = '{SLOT_ZI, SLOT_YJ, KIND_YZ, NEG};
            6'd30:   e = '{SLOT_XJ, SLOT_YJ, KIND_XY, POS};
            6'd31:   e = '{SLOT_YJ, SLOT_XJ, KIND_XY, POS};
            6'd32:   e = '{SLOT_XJ, SLOT_ZJ, KIND_XZ, POS};
            6'd33:   e = '{SLOT_ZJ, SLOT_XJ, KIND_XZ, POS};
            6'd34:   e = '{SLOT_ZJ, SLOT_YJ, KIND_YZ, POS};
            6'd35:   e = '{SLOT_YJ, SLOT_ZJ, KIND_YZ, POS};
            default: e = '{SLOT_XI, SLOT_XI, KIND_XX, POS};
        endcase
        return e;
    endfunction

endpackage

// ----- hdl/elh_front.sv -----
// front part: takes an edge, forms the six hessian values with one shared multiplier
`timescale 1ns / 1ps

module elh_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  elh_pkg::t_edge_in i_in_data,
    input  logic              i_cfg_valid,
    input  logic [16:0]       i_cfg_data,
    input  elh_pkg::t_qstat   i_qstat,
    output logic              o_push,
    output elh_pkg::t_qentry  o_push_data
);
    import elh_pkg::*;

    logic signed [D_W-1:0]    r_d [AXES];
    logic [LEN_W-1:0]         r_len;
    logic [VTX_W-1:0]         r_vi;
    logic [VTX_W-1:0]         r_vj;
    logic                     r_fin;
    logic                     r_busy;
    logic [STEP_W-1:0]        r_step;
    logic signed [PROD_W-1:0] r_p [MUL_STEPS];
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_v [AXES];
    logic [VTX_W-1:0]         r_pc;

    logic signed [D_W-1:0]    w_op_a;
    logic signed [D_W-1:0]    w_op_b;
    logic signed [PROD_W-1:0] w_prod;
    logic [VTX_W-1:0]         w_cfg;
    logic                     w_accept;
    logic [IDX_W-1:0]         w_pc1;
    logic [IDX_W-1:0]         w_pc2;
    logic [IDX_W-1:0]         w_vi;
    logic [IDX_W-1:0]         w_vj;

    assign w_accept   = i_in_valid && !r_busy;
    assign o_in_stall = r_busy;

    // point count clamped into the legal range
    always_comb begin
        w_cfg = i_cfg_data;
        if (w_cfg == '0) begin
            w_cfg = VTX_W'(1);
        end else if (w_cfg > VTX_W'(MAX_VERTICES)) begin
            w_cfg = VTX_W'(MAX_VERTICES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= VTX_W'(1);
        end else if (i_cfg_valid) begin
            r_pc <= w_cfg;
        end
    end

    always_comb begin
        case (r_step)
            STEP_LL: begin
                w_op_a = $signed({2'b00, r_len});
                w_op_b = $signed({2'b00, r_len});
            end
            STEP_XX: begin
                w_op_a = r_d[0];
                w_op_b = r_d[0];
            end
            STEP_YY: begin
                w_op_a = r_d[1];
                w_op_b = r_d[1];
            end
            STEP_ZZ: begin
                w_op_a = r_d[2];
                w_op_b = r_d[2];
            end
            STEP_XY: begin
                w_op_a = r_d[0];
                w_op_b = r_d[1];
            end
            STEP_XZ: begin
                w_op_a = r_d[0];
                w_op_b = r_d[2];
            end
            STEP_YZ: begin
                w_op_a = r_d[1];
                w_op_b = r_d[2];
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_prod = PROD_W'(w_op_a) * PROD_W'(w_op_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_LL;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_step <= STEP_LL;
        end else if (r_busy) begin
            if (r_step == STEP_PUSH) begin
                if (!i_qstat.full) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_d[0] <= D_W'(i_in_data.first_x) - D_W'(i_in_data.second_x);
            r_d[1] <= D_W'(i_in_data.first_y) - D_W'(i_in_data.second_y);
            r_d[2] <= D_W'(i_in_data.first_z) - D_W'(i_in_data.second_z);
            r_len  <= i_in_data.target_length;
            r_vi   <= i_in_data.first_vertex;
            r_vj   <= i_in_data.second_vertex;
            r_fin  <= i_in_data.mesh_final_edge;
        end
        if (r_busy && r_step <= STEP_YZ) begin
            r_p[r_step[2:0]] <= w_prod;
        end
        // |d|^2 - l^2 gathered one product at a time
        if (r_busy) begin
            if (r_step == STEP_XX) begin
                r_acc <= -ACC_W'(r_p[0]);
            end else if (r_step == STEP_YY || r_step == STEP_ZZ || r_step == STEP_XY) begin
                r_acc <= r_acc + ACC_W'(r_p[3'(r_step - STEP_W'(1))]);
            end
        end
        if (r_busy && r_step >= STEP_XZ && r_step <= STEP_DIAG) begin
            r_v[2'(r_step - STEP_XZ)] <= (r_acc <<< 2)
                + (ACC_W'(r_p[3'(r_step - STEP_XY)]) <<< 3);
        end
    end

    assign w_pc1 = {1'b0, r_pc};
    assign w_pc2 = {r_pc, 1'b0};
    assign w_vi  = {1'b0, r_vi};
    assign w_vj  = {1'b0, r_vj};

    assign o_push = r_busy && (r_step == STEP_PUSH) && !i_qstat.full;

    always_comb begin
        o_push_data.vals[KIND_XX] = r_v[0];
        o_push_data.vals[KIND_YY] = r_v[1];
        o_push_data.vals[KIND_ZZ] = r_v[2];
        o_push_data.vals[KIND_XY] = ACC_W'(r_p[4]) <<< 3;
        o_push_data.vals[KIND_XZ] = ACC_W'(r_p[5]) <<< 3;
        o_push_data.vals[KIND_YZ] = ACC_W'(r_p[6]) <<< 3;
        // index sums wrap at the index width
        o_push_data.slot[SLOT_XI] = w_vi;
        o_push_data.slot[SLOT_YI] = w_vi + w_pc1;
        o_push_data.slot[SLOT_ZI] = w_vi + w_pc2;
        o_push_data.slot[SLOT_XJ] = w_vj;
        o_push_data.slot[SLOT_YJ] = w_vj + w_pc1;
        o_push_data.slot[SLOT_ZJ] = w_vj + w_pc2;
        o_push_data.fin           = r_fin;
    end

endmodule

// ----- hdl/elh_queue.sv -----
// two-entry queue between the front and the back part
`timescale 1ns / 1ps

module elh_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  elh_pkg::t_qentry i_push_data,
    input  logic             i_pop,
    output elh_pkg::t_qentry o_pop_data,
    output elh_pkg::t_qstat  o_qstat
);
    import elh_pkg::*;

    t_qentry    r_mem [QUEUE_DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_pop_data    = r_mem[r_rd_ptr];
    assign o_qstat.full  = (r_count == 2'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_count == '0);

endmodule

// ----- hdl/elh_back.sv -----
// back part: walks the fixed triplet order and drives the output register
`timescale 1ns / 1ps

module elh_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  elh_pkg::t_qstat    i_qstat,
    input  elh_pkg::t_qentry   i_pop_data,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output elh_pkg::t_trip_out o_out_data
);
    import elh_pkg::*;

    t_qentry   r_cur;
    logic      r_cur_valid;
    logic [K_W-1:0] r_k;
    logic      r_out_valid;
    t_trip_out r_out;

    t_tab                    w_e;
    logic signed [ACC_W-1:0] w_v;
    logic signed [ACC_W-1:0] w_vs;
    logic signed [VAL_W-1:0] w_sat;
    logic                    w_emit;
    logic                    w_last;

    assign w_e    = tab_lookup(r_k);
    assign w_last = (r_k == K_W'(TRIPLETS - 1));
    assign w_emit = r_cur_valid && (!r_out_valid || !i_out_stall);
    assign o_pop  = !i_qstat.empty && (!r_cur_valid || (w_emit && w_last));

    always_comb begin
        w_v  = $signed(r_cur.vals[w_e.kind]);
        w_vs = w_e.neg ? -w_v : w_v;
        // saturate to the signed 64-bit range
        if (&w_vs[ACC_W-1:VAL_W-1] || ~|w_vs[ACC_W-1:VAL_W-1]) begin
            w_sat = w_vs[VAL_W-1:0];
        end else if (w_vs[ACC_W-1]) begin
            w_sat = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_k         <= w_last ? '0 : r_k + K_W'(1);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_cur_valid <= 1'b1;
            end else if (w_emit && w_last) begin
                r_cur_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_pop_data;
        end
        if (w_emit) begin
            r_out.row_index    <= r_cur.slot[w_e.row_slot];
            r_out.col_index    <= r_cur.slot[w_e.col_slot];
            r_out.entry_value  <= w_sat;
            r_out.last_of_edge <= w_last;
            r_out.mesh_done    <= w_last && r_cur.fin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hdl/edge_length_energy_hessian.sv -----
// top level of the squared edge length energy hessian block
`timescale 1ns / 1ps

// Each accepted edge yields the 36 (row, column, value) triplets of its 6x6 Hessian
// block in a fixed order, one triplet per cycle while the output is not stalled;
// that walk in the back part sets the sustained rate. In the front part one shared
// 33x33 signed multiplier forms l*l and the six products of the coordinate difference
// in turn, followed by the diagonal sums and the hand-over to a two-entry queue, so
// up to two finished edges wait while the back part is still emitting. On an idle
// block the first triplet of an edge passes the front sequencer, the queue and the
// back part's current-entry register before it is registered at the output.
// The point count register is written through its own channel, which is always
// ready; write it only while no edge is in flight.

module edge_length_energy_hessian (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  elh_pkg::t_edge_in  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output elh_pkg::t_trip_out o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [16:0]        i_cfg_data
);
    import elh_pkg::*;

    t_qstat  w_qstat;
    t_qentry w_push_data;
    t_qentry w_pop_data;
    logic    w_push;
    logic    w_pop;

    assign o_cfg_ready = 1'b1;

    elh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_qstat     (w_qstat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    elh_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_qstat     (w_qstat)
    );

    elh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (w_qstat),
        .i_pop_data  (w_pop_data),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- hdl/elh_checker.sv -----
// port-level checks of the edge hessian block and their binding
`timescale 1ns / 1ps

module elh_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input elh_pkg::t_trip_out o_out_data
);

    // a stalled triplet stays offered
    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // mesh end only ever marks the closing triplet of an edge
    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.mesh_done |-> o_out_data.last_of_edge)
        else $error("mesh done without last of edge");

    // the front is busy straight after taking an edge
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after a transfer");

endmodule

bind edge_length_energy_hessian elh_port_checker u_elh_checker (.*);

// ----- tb/sv/elh_checker.sv -----
// checker for the edge hessian block: tracks the point count, predicts every triplet, compares
`timescale 1ns / 1ps

module elh_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  elh_pkg::t_edge_in  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  elh_pkg::t_trip_out i_out_data,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [16:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_checked
);

    import elh_pkg::*;

    localparam int WIDE_W = 96;

    typedef logic signed [WIDE_W-1:0] t_wide;

    localparam t_wide WIDE_MAX = t_wide'(64'h7FFF_FFFF_FFFF_FFFF);
    localparam t_wide WIDE_MIN = -WIDE_MAX - 1;

    logic [VTX_W-1:0] point_count;
    t_trip_out        expected_triplets [$];
    int               errors;
    int               checked;

    // row slot, column slot, value kind and sign of the k-th triplet of an edge
    function automatic t_tab triplet_layout(input int k);
        case (k)
            0:       return {SLOT_XI, SLOT_XI, KIND_XX, POS};
            1:       return {SLOT_XJ, SLOT_XJ, KIND_XX, POS};
            2:       return {SLOT_YI, SLOT_YI, KIND_YY, POS};
            3:       return {SLOT_YJ, SLOT_YJ, KIND_YY, POS};
            4:       return {SLOT_ZI, SLOT_ZI, KIND_ZZ, POS};
            5:       return {SLOT_ZJ, SLOT_ZJ, KIND_ZZ, POS};
            6:       return {SLOT_XI, SLOT_YI, KIND_XY, POS};
            7:       return {SLOT_YI, SLOT_XI, KIND_XY, POS};
            8:       return {SLOT_ZI, SLOT_XI, KIND_XZ, POS};
            9:       return {SLOT_XI, SLOT_ZI, KIND_XZ, POS};
            10:      return {SLOT_YI, SLOT_ZI, KIND_YZ, POS};
            11:      return {SLOT_ZI, SLOT_YI, KIND_YZ, POS};
            12:      return {SLOT_XI, SLOT_XJ, KIND_XX, NEG};
            13:      return {SLOT_XJ, SLOT_XI, KIND_XX, NEG};
            14:      return {SLOT_YI, SLOT_YJ, KIND_YY, NEG};
            15:      return {SLOT_YJ, SLOT_YI, KIND_YY, NEG};
            16:      return {SLOT_ZI, SLOT_ZJ, KIND_ZZ, NEG};
            17:      return {SLOT_ZJ, SLOT_ZI, KIND_ZZ, NEG};
            18:      return {SLOT_XI, SLOT_YJ, KIND_XY, NEG};
            19:      return {SLOT_YJ, SLOT_XI, KIND_XY, NEG};
            20:      return {SLOT_ZJ, SLOT_XI, KIND_XZ, NEG};
            21:      return {SLOT_XI, SLOT_ZJ, KIND_XZ, NEG};
            22:      return {SLOT_YI, SLOT_XJ, KIND_XY, NEG};
            23:      return {SLOT_XJ, SLOT_YI, KIND_XY, NEG};
            24:      return {SLOT_YI, SLOT_ZJ, KIND_YZ, NEG};
            25:      return {SLOT_ZJ, SLOT_YI, KIND_YZ, NEG};
            26:      return {SLOT_XJ, SLOT_ZI, KIND_XZ, NEG};
            27:      return {SLOT_ZI, SLOT_XJ, KIND_XZ, NEG};
            28:      return {SLOT_YJ, SLOT_ZI, KIND_YZ, NEG};
            29:      return {SLOT_ZI, SLOT_YJ, KIND_YZ, NEG};
            30:      return {SLOT_XJ, SLOT_YJ, KIND_XY, POS};
            31:      return {SLOT_YJ, SLOT_XJ, KIND_XY, POS};
            32:      return {SLOT_XJ, SLOT_ZJ, KIND_XZ, POS};
            33:      return {SLOT_ZJ, SLOT_XJ, KIND_XZ, POS};
            34:      return {SLOT_ZJ, SLOT_YJ, KIND_YZ, POS};
            default: return {SLOT_YJ, SLOT_ZJ, KIND_YZ, POS};
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp_value(input t_wide v);
        if (v > WIDE_MAX)
            return {1'b0, {(VAL_W-1){1'b1}}};
        if (v < WIDE_MIN)
            return {1'b1, {(VAL_W-1){1'b0}}};
        return v[VAL_W-1:0];
    endfunction

    function automatic logic [VTX_W-1:0] clamp_count(input logic [16:0] raw);
        if (raw == 17'd0)
            return 17'd1;
        if (raw > 17'(MAX_VERTICES))
            return 17'(MAX_VERTICES);
        return raw;
    endfunction

    // exact wide arithmetic, the only rounding is the final clamp to 64 bits
    task automatic predict_edge(input t_edge_in e);
        t_wide            dlt [AXES];
        t_wide            len;
        t_wide            base;
        t_wide            vals [KINDS];
        t_wide            v;
        int unsigned      sum;
        logic [IDX_W-1:0] slot [SLOTS];
        t_tab             lay;
        t_trip_out        t;
        dlt[0] = t_wide'($signed(e.first_x)) - t_wide'($signed(e.second_x));
        dlt[1] = t_wide'($signed(e.first_y)) - t_wide'($signed(e.second_y));
        dlt[2] = t_wide'($signed(e.first_z)) - t_wide'($signed(e.second_z));
        len    = t_wide'({1'b0, e.target_length});
        base   = 4 * (dlt[0] * dlt[0] + dlt[1] * dlt[1] + dlt[2] * dlt[2] - len * len);
        vals[KIND_XX] = base + 8 * dlt[0] * dlt[0];
        vals[KIND_YY] = base + 8 * dlt[1] * dlt[1];
        vals[KIND_ZZ] = base + 8 * dlt[2] * dlt[2];
        vals[KIND_XY] = 8 * dlt[0] * dlt[1];
        vals[KIND_XZ] = 8 * dlt[0] * dlt[2];
        vals[KIND_YZ] = 8 * dlt[1] * dlt[2];
        // index sums wrap to the index width, vertex numbers are not range checked
        for (int a = 0; a < AXES; a++) begin
            sum = e.first_vertex + a * point_count;
            slot[a] = sum[IDX_W-1:0];
            sum = e.second_vertex + a * point_count;
            slot[AXES+a] = sum[IDX_W-1:0];
        end
        for (int k = 0; k < TRIPLETS; k++) begin
            lay = triplet_layout(k);
            v = vals[lay.kind];
            if (lay.neg == NEG)
                v = -v;
            t.row_index    = slot[lay.row_slot];
            t.col_index    = slot[lay.col_slot];
            t.entry_value  = clamp_value(v);
            t.last_of_edge = (k == TRIPLETS - 1);
            t.mesh_done    = t.last_of_edge & e.mesh_final_edge;
            expected_triplets.push_back(t);
        end
    endtask

    task automatic check_triplet(input t_trip_out got);
        t_trip_out want;
        checked++;
        if (expected_triplets.size() == 0) begin
            errors++;
            $display("%0t: triplet %0d expected none, actual row %0d col %0d value %0d last %0b done %0b",
                     $time, checked, got.row_index, got.col_index, $signed(got.entry_value),
                     got.last_of_edge, got.mesh_done);
            return;
        end
        want = expected_triplets.pop_front();
        if (got.row_index !== want.row_index || got.col_index !== want.col_index ||
            got.entry_value !== want.entry_value || got.last_of_edge !== want.last_of_edge ||
            got.mesh_done !== want.mesh_done) begin
            errors++;
            $display("%0t: triplet %0d expected row %0d col %0d value %0d last %0b done %0b",
                     $time, checked, want.row_index, want.col_index,
                     $signed(want.entry_value), want.last_of_edge, want.mesh_done);
            $display("%0t: triplet %0d actual   row %0d col %0d value %0d last %0b done %0b",
                     $time, checked, got.row_index, got.col_index,
                     $signed(got.entry_value), got.last_of_edge, got.mesh_done);
        end
    endtask

    initial begin
        point_count = 17'd1;
        errors      = 0;
        checked     = 0;
        o_errors    = 0;
        o_pending   = 0;
        o_checked   = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            point_count = 17'd1;
            expected_triplets.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                check_triplet(i_out_data);
            if (i_in_valid && !i_in_stall)
                predict_edge(i_in_data);
            if (i_cfg_valid && i_cfg_ready)
                point_count = clamp_count(i_cfg_data);
        end
        o_errors  <= errors;
        o_pending <= expected_triplets.size();
        o_checked <= checked;
    end

endmodule

// ----- tb/sv/testbench.sv -----
// top of the edge hessian testbench: clock, reset, edge and register stimulus, verdict
`timescale 1ns / 1ps

module testbench;

    import elh_pkg::*;

    localparam int RUN_LIMIT_NS = 600000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] C_ONE = 32'sh0001_0000;
    localparam logic signed [COORD_W-1:0] C_P30 = 32'sh4000_0000;
    localparam logic [LEN_W-1:0]          L_MAX = 31'h7FFF_FFFF;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       edge_valid = 1'b0;
    logic       edge_stall;
    t_edge_in   edge_data  = '0;
    logic       trip_valid;
    logic       trip_stall = 1'b0;
    t_trip_out  trip_data;
    logic       cfg_valid  = 1'b0;
    logic       cfg_ready;
    logic [16:0] cfg_data  = '0;

    int          check_errors;
    int          pending_triplets;
    int          checked_triplets;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_asked    = 0;
    int          hold_taken    = 0;
    int          hold_left     = 0;
    int          edges_sent    = 0;
    logic [16:0] vertex_limit  = 17'd1;

    always #1 clk = ~clk;

    edge_length_energy_hessian u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (edge_valid),
        .o_in_stall  (edge_stall),
        .i_in_data   (edge_data),
        .o_out_valid (trip_valid),
        .i_out_stall (trip_stall),
        .o_out_data  (trip_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    elh_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (edge_valid),
        .i_in_stall  (edge_stall),
        .i_in_data   (edge_data),
        .i_out_valid (trip_valid),
        .i_out_stall (trip_stall),
        .i_out_data  (trip_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_errors    (check_errors),
        .o_pending   (pending_triplets),
        .o_checked   (checked_triplets)
    );

    // receiver: random stalls, or a long hold-off when the stimulus asks for one
    always @(posedge clk) begin
        if (hold_left > 0) begin
            trip_stall <= 1'b1;
            hold_left  <= hold_left - 1;
        end else if (hold_taken != hold_asked) begin
            hold_taken <= hold_asked;
            hold_left  <= HOLD_CYCLES;
            trip_stall <= 1'b1;
        end else begin
            trip_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic t_edge_in make_edge(
        input logic [VTX_W-1:0] vi, input logic [VTX_W-1:0] vj,
        input logic signed [COORD_W-1:0] fx, input logic signed [COORD_W-1:0] fy,
        input logic signed [COORD_W-1:0] fz, input logic signed [COORD_W-1:0] sx,
        input logic signed [COORD_W-1:0] sy, input logic signed [COORD_W-1:0] sz,
        input logic [LEN_W-1:0] len, input logic fin);
        t_edge_in e;
        e.first_vertex    = vi;
        e.second_vertex   = vj;
        e.first_x         = fx;
        e.first_y         = fy;
        e.first_z         = fz;
        e.second_x        = sx;
        e.second_y        = sy;
        e.second_z        = sz;
        e.target_length   = len;
        e.mesh_final_edge = fin;
        return e;
    endfunction

    function automatic logic signed [COORD_W-1:0] extreme_coord();
        case ($urandom_range(4))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return '0;
            3:       return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    function automatic int jitter(input int span);
        return int'($urandom_range(0, span)) - span / 2;
    endfunction

    function automatic t_edge_in random_edge();
        t_edge_in e;
        int       pick;
        int       span;
        pick = $urandom_range(99);
        e.first_vertex    = 17'($urandom_range(1, vertex_limit));
        e.second_vertex   = 17'($urandom_range(1, vertex_limit));
        e.mesh_final_edge = ($urandom_range(9) == 0);
        if (pick < 60) begin
            // plausible mesh edge: nearby points, target length of the same order
            span = 1 << $urandom_range(4, 24);
            e.first_x       = $signed($urandom) >>> 4;
            e.first_y       = $signed($urandom) >>> 4;
            e.first_z       = $signed($urandom) >>> 4;
            e.second_x      = e.first_x + jitter(span);
            e.second_y      = e.first_y + jitter(span);
            e.second_z      = e.first_z + jitter(span);
            e.target_length = 31'($urandom_range(0, span));
        end else if (pick < 78) begin
            e = t_edge_in'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom});
        end else if (pick < 88) begin
            // zero length on some or all axes
            e.first_x       = $urandom;
            e.first_y       = $urandom;
            e.first_z       = $urandom;
            e.second_x      = $urandom_range(1) ? e.first_x : 32'($urandom);
            e.second_y      = $urandom_range(1) ? e.first_y : 32'($urandom);
            e.second_z      = e.first_z;
            e.target_length = 31'($urandom);
        end else begin
            e.first_x       = extreme_coord();
            e.first_y       = extreme_coord();
            e.first_z       = extreme_coord();
            e.second_x      = extreme_coord();
            e.second_y      = extreme_coord();
            e.second_z      = extreme_coord();
            case ($urandom_range(3))
                0:       e.target_length = '0;
                1:       e.target_length = L_MAX;
                2:       e.target_length = 31'd1;
                default: e.target_length = 31'($urandom);
            endcase
        end
        return e;
    endfunction

    // valid stays up between back-to-back transfers, it only drops for a gap
    task automatic offer_edge(input t_edge_in e);
        while ($urandom_range(99) < send_idle_pct) begin
            edge_valid <= 1'b0;
            @(posedge clk);
        end
        edge_valid <= 1'b1;
        edge_data  <= e;
        do @(posedge clk); while (edge_stall);
        edges_sent++;
    endtask

    task automatic send_random(input int count);
        repeat (count) offer_edge(random_edge());
    endtask

    // sender pauses until every triplet of the edges in flight has come out
    task automatic settle();
        edge_valid <= 1'b0;
        do @(posedge clk); while (pending_triplets != 0);
    endtask

    task automatic set_point_count(input logic [16:0] raw);
        cfg_valid <= 1'b1;
        cfg_data  <= raw;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        vertex_limit = (raw == 17'd0) ? 17'd1 :
                       (raw > 17'(MAX_VERTICES)) ? 17'(MAX_VERTICES) : raw;
    endtask

    task automatic set_idle(input int sender, input int receiver);
        send_idle_pct = sender;
        recv_idle_pct = receiver;
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // point count still at its reset value of one
        offer_edge(make_edge(1, 1, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        offer_edge(make_edge(1, 1, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 0, 1'b0));
        offer_edge(make_edge(1, 1, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, L_MAX, 1'b0));
        offer_edge(make_edge(1, 1, C_MAX, C_MIN, 0, C_MIN, C_MAX, 0, 0, 1'b0));
        offer_edge(make_edge(1, 1, C_ONE, -C_ONE, C_MAX, C_ONE, -C_ONE, C_MAX, L_MAX, 1'b0));
        // off-diagonal product right at the top of the 64-bit range
        offer_edge(make_edge(1, 1, C_P30, C_P30, 0, 0, 0, 0, 0, 1'b0));
        offer_edge(make_edge(1, 1, C_P30, C_P30 - 1, 0, 0, 0, 0, 0, 1'b0));
        offer_edge(make_edge(1, 1, C_P30, 0, -C_P30, 0, 0, 0, 0, 1'b0));
        offer_edge(make_edge(1, 1, C_ONE, 2 * C_ONE, 3 * C_ONE, 0, 0, 0, 31'h2_0000, 1'b1));
        offer_edge(make_edge(1, 1, -1, 0, 1, 1, 0, -1, 31'd1, 1'b1));
        settle();

        // largest point count, vertex numbers at and beyond it
        set_point_count(17'(MAX_VERTICES));
        offer_edge(make_edge(17'(MAX_VERTICES), 17'(MAX_VERTICES), C_ONE, 0, 0, 0, C_ONE, 0,
                             31'h1_0000, 1'b0));
        offer_edge(make_edge(17'h1FFFF, 1, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, L_MAX,
                             1'b0));
        offer_edge(make_edge(0, 0, 32'sh1234_5678, -32'sh0765_4321, 32'sh0F0F_0F0F,
                             -32'sh7000_0000, 32'sh0BAD_F00D, -32'sh0000_0001, 31'h5555_5555,
                             1'b1));
        offer_edge(make_edge(1, 17'(MAX_VERTICES), 32'sd1, 32'sd1, 32'sd1, 0, 0, 0, 31'd1,
                             1'b0));
        settle();

        set_point_count(17'($urandom_range(2, 1000)));
        set_idle(27, 59);
        send_random(50);
        // long receiver hold-off while the sender keeps offering
        hold_asked++;
        send_random(12);
        settle();

        // zero is taken as one
        set_point_count(17'd0);
        set_idle(59, 27);
        send_random(60);
        settle();

        // above the maximum is taken as the maximum
        set_point_count(17'h1FFFF);
        set_idle(0, 0);
        send_random(30);
        settle();

        set_point_count(17'($urandom_range(2, MAX_VERTICES)));
        send_random(30);
        settle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("testbench: %0d edges sent, %0d triplets checked", edges_sent, checked_triplets);
        $display("testbench: point counts 1, 65536, clamped writes and random; idle mixes 27/59, 59/27, none");
        if (check_errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("testbench: timed out with %0d triplets outstanding", pending_triplets);
        $display("testbench: done, errors");
        $finish;
    end

endmodule
